// ----- rtl/pn_pkg.sv -----
package pn_pkg;

	localparam int MAX_INPUTS  = 64;
	localparam int SLOT_W      = $clog2(MAX_INPUTS);
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH) + 1;
	localparam int POS_W       = 16;
	localparam int ACC_W       = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] Q_ONE     = 64'd1 << 30;
	localparam logic [63:0] TANH_STEP = 64'd2 * ((64'd8 << 30) / 64'(TABLE_DEPTH));

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_BIAS  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [2:0] MODE_LOGISTIC = 3'd0;
	localparam logic [2:0] MODE_TANH     = 3'd1;
	localparam logic [2:0] MODE_STEP     = 3'd2;
	localparam logic [2:0] MODE_SIGN     = 3'd3;

	localparam logic [0:0] ACT_WEIGHT  = 1'b0;
	localparam logic [0:0] ACT_ELEMENT = 1'b1;

	typedef struct packed {
		logic [0:0]         action;
		logic [5:0]         weight_slot;
		logic signed [15:0] sample_value;
		logic [0:0]         last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] combination_out;
		logic signed [15:0] activation_out;
		logic signed [15:0] derivative_out;
		logic [0:0]         not_derivable;
		logic [0:0]         count_mismatch;
	} out_item_t;

	typedef struct packed {
		logic [2:0]         activation_mode;
		logic signed [15:0] bias_value;
		logic [6:0]         input_count;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic signed [15:0] weight;
		logic               first;
		logic               last;
		logic               in_range;
		logic               mismatch;
	} elem_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_ROUND,
		BK_LOOK,
		BK_INTERP,
		BK_FINAL,
		BK_OUT
	} bk_state_t;

	typedef logic [15:0] squash_tbl_t [TABLE_DEPTH];

	// shift and subtract quotient, evaluated only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic squash_tbl_t build_squash();
		squash_tbl_t tbl;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] t1;
		logic [63:0] t;
		term = Q_ONE;
		e    = Q_ONE;
		t    = 64'd0;
		for (int n = 1; n <= 20; n++) begin
			term = udiv64((term * TANH_STEP) >> 30, 64'(n));
			e    = e + term;
		end
		t1     = udiv64((e - Q_ONE) << 30, e + Q_ONE);
		tbl[0] = 16'd0;
		for (int k = 1; k < TABLE_DEPTH; k++) begin
			t      = udiv64((t + t1) << 30, Q_ONE + ((t * t1) >> 30));
			tbl[k] = 16'((t + (64'd1 << 17)) >> 18);
		end
		return tbl;
	endfunction

	localparam squash_tbl_t SQUASH = build_squash();

	function automatic logic [12:0] table_at(input logic [IDX_W-1:0] idx);
		if (idx >= IDX_W'(TABLE_DEPTH)) begin
			return 13'd4096;
		end
		return 13'(SQUASH[idx[IDX_W-2:0]]);
	endfunction

endpackage

// ----- rtl/pn_front.sv -----
module pn_front
	import pn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  cfg_t     cfg,
	output logic     push,
	output elem_t    push_elem,
	input  logic     q_full
);

	logic signed [15:0] weight_mem [MAX_INPUTS];
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_inc;
	logic               accept;
	logic               is_elem;
	logic               valid_s1;
	logic signed [15:0] weight_s1;
	elem_t              elem_s1;

	assign accept   = in_valid && !in_stall;
	assign is_elem  = (in_item.action == ACT_ELEMENT);
	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		push_elem        = elem_s1;
		push_elem.weight = weight_s1;
	end

	always_ff @(posedge clk) begin
		if (accept && !is_elem) begin
			weight_mem[in_item.weight_slot] <= in_item.sample_value;
		end
		if (accept && is_elem) begin
			weight_s1 <= weight_mem[pos_q[SLOT_W-1:0]];
			elem_s1.sample   <= in_item.sample_value;
			elem_s1.weight   <= '0;
			elem_s1.first    <= (pos_q == '0);
			elem_s1.last     <= in_item.last_element[0];
			elem_s1.in_range <= (pos_q < POS_W'(MAX_INPUTS));
			elem_s1.mismatch <= (pos_inc != POS_W'(cfg.input_count));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && is_elem) begin
				pos_q <= in_item.last_element[0] ? '0 : pos_inc;
			end
			if (accept && is_elem) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/pn_queue.sv -----
module pn_queue
	import pn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  elem_t push_elem,
	output logic  full,
	input  logic  pop,
	output logic  q_valid,
	output elem_t head
);

	elem_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/pn_back.sv -----
module pn_back
	import pn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  elem_t     head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic               valid_s1;
	logic signed [31:0] prod_s1;
	logic               first_s1;
	logic               last_s1;
	logic               mis_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   acc_base;
	logic               mis_q;
	logic signed [15:0] c_q;
	logic [12:0]        lo_q;
	logic [12:0]        hi_q;
	logic [15:0]        frac_q;
	logic [12:0]        t_q;
	logic               log_mode;
	out_item_t          out_q;

	logic signed [ACC_W:0]  rnd;
	logic signed [28:0]     cv;
	logic signed [15:0]     c_sat;
	logic [16:0]            m;
	logic [IDX_W-1:0]       idx;
	logic [12:0]            diff;
	logic [28:0]            interp;
	logic [12:0]            t_new;
	logic signed [13:0]     ts;
	logic signed [14:0]     s_sum;
	logic [12:0]            s;
	logic [25:0]            s_prod;
	logic [25:0]            t_sq;
	logic signed [15:0]     act;
	logic signed [15:0]     der;
	logic                   nd;

	assign log_mode = (cfg.activation_mode == MODE_LOGISTIC);
	assign out_valid = (state_q == BK_OUT);
	assign out_item  = out_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_RUN: begin
				pop = q_valid && !(valid_s1 && last_s1);
				if (valid_s1 && last_s1) begin
					state_d = BK_ROUND;
				end
			end
			BK_ROUND:  state_d = BK_LOOK;
			BK_LOOK:   state_d = BK_INTERP;
			BK_INTERP: state_d = BK_FINAL;
			BK_FINAL:  state_d = BK_OUT;
			BK_OUT: begin
				if (!out_stall) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_RUN;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= pop;
		end
	end

	// rounding and saturation to q4.12
	always_comb begin
		rnd = $signed({acc_q[ACC_W-1], acc_q}) + (ACC_W+1)'(2048);
		cv  = 29'(rnd >>> 12);
		if (cv > 29'sd32767) begin
			c_sat = 16'sd32767;
		end else if (cv < -29'sd32768) begin
			c_sat = -16'sd32768;
		end else begin
			c_sat = 16'(cv);
		end
	end

	always_comb begin
		m   = c_q[15] ? 17'(-$signed({c_q[15], c_q})) : 17'(c_q);
		idx = log_mode ? IDX_W'(m[16:8]) : IDX_W'(m[16:7]);
	end

	always_comb begin
		diff   = hi_q - lo_q;
		interp = 29'(diff) * 29'(frac_q);
		if (log_mode) begin
			t_new = lo_q + 13'((interp + 29'd32768) >> 16);
		end else begin
			t_new = lo_q + 13'((interp + 29'd16384) >> 15);
		end
	end

	always_comb begin
		ts     = c_q[15] ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});
		s_sum  = 15'sd4097 + 15'(ts);
		s      = 13'(s_sum >>> 1);
		s_prod = 26'(s) * 26'(13'd4096 - s) + 26'd2048;
		t_sq   = 26'(t_q) * 26'(t_q) + 26'd2048;
		nd     = 1'b0;
		case (cfg.activation_mode)
			MODE_LOGISTIC: begin
				act = 16'(s);
				der = 16'(s_prod >> 12);
			end
			MODE_TANH: begin
				act = 16'(ts);
				der = 16'sd4096 - 16'(t_sq >> 12);
			end
			MODE_STEP: begin
				act = c_q[15] ? 16'sd0 : 16'sd4096;
				der = 16'sd0;
				nd  = (c_q == '0);
			end
			MODE_SIGN: begin
				act = c_q[15] ? -16'sd4096 : 16'sd4096;
				der = 16'sd0;
				nd  = (c_q == '0);
			end
			default: begin
				act = c_q;
				der = 16'sd4096;
			end
		endcase
	end

	assign acc_base = first_s1 ? ACC_W'({{(ACC_W-16){cfg.bias_value[15]}}, cfg.bias_value} << 12)
		: acc_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= head.in_range ? head.weight * head.sample : 32'sd0;
			first_s1 <= head.first;
			last_s1  <= head.last;
			mis_s1   <= head.mismatch;
		end
		if (valid_s1) begin
			acc_q <= acc_base + ACC_W'(prod_s1);
			mis_q <= mis_s1;
		end
		case (state_q)
			BK_ROUND: c_q <= c_sat;
			BK_LOOK: begin
				lo_q   <= table_at(idx);
				hi_q   <= table_at(idx + IDX_W'(1));
				frac_q <= log_mode ? {m[7:0], 8'd0} : {1'b0, m[6:0], 8'd0};
			end
			BK_INTERP: t_q <= t_new;
			BK_FINAL: begin
				out_q.combination_out <= c_q;
				out_q.activation_out  <= act;
				out_q.derivative_out  <= der;
				out_q.not_derivable   <= nd;
				out_q.count_mismatch  <= mis_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/perceptron_neuron.sv -----
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_item  (in_item_t)
// out     | out_valid | out_stall | out_item (out_item_t)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// the front takes one transaction per cycle; weight writes end there, elements enter a four-entry queue
// the back end does one multiply-accumulate per element per cycle while running with elements queued
// after the last element of a vector the back end takes no element until it has gone through its steps
// (accumulate, round, table lookup, interpolation, activation and derivative, output register)
// reset clears control and loads the register defaults; the weight store is not cleared
// a stalled output transaction holds the back end; the front keeps taking items until the queue fills
module perceptron_neuron
	import pn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg_q;
	logic  push;
	elem_t push_elem;
	logic  q_full;
	logic  q_valid;
	logic  pop;
	elem_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.activation_mode <= MODE_TANH;
			cfg_q.bias_value      <= '0;
			cfg_q.input_count     <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  cfg_q.activation_mode <= cfg_data[2:0];
				REG_BIAS:  cfg_q.bias_value      <= cfg_data;
				REG_COUNT: cfg_q.input_count     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	pn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.push      (push),
		.push_elem (push_elem),
		.q_full    (q_full)
	);

	pn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_elem (push_elem),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	pn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import pn_pkg::*;

	localparam logic [2:0] MODE_LINEAR = 3'd4;
	localparam int DRAIN_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [15:0] cfg_data = '0;

	perceptron_neuron i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// neuron state as predicted
	logic [15:0]  tanh_tbl [TABLE_DEPTH];
	logic signed [15:0] weights [MAX_INPUTS];
	logic [39:0]  acc;
	int unsigned  elem_pos;
	logic [2:0]   mode;
	logic signed [15:0] bias;
	logic [6:0]   elem_count;

	in_item_t  pending [$];
	out_item_t expected_q [$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        no_idle = 1'b0;

	// generator view of the vector position and written slots
	int unsigned gen_pos = 0;
	bit [MAX_INPUTS-1:0] slot_written = '0;

	function automatic void fill_tanh_tbl();
		longint unsigned one, a, term, e, t1, t;
		one = 64'd1 << 30;
		a = 2 * ((8 * one) / TABLE_DEPTH);
		term = one;
		e = one;
		t = 0;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * a) >> 30) / n;
			e = e + term;
		end
		t1 = ((e - one) << 30) / (e + one);
		tanh_tbl[0] = 16'd0;
		for (int k = 1; k < TABLE_DEPTH; k++) begin
			t = ((t + t1) << 30) / (one + ((t * t1) >> 30));
			tanh_tbl[k] = 16'((t + (64'd1 << 17)) >> 18);
		end
	endfunction

	function automatic longint unsigned tbl_entry(longint unsigned idx);
		return idx < TABLE_DEPTH ? longint'(tanh_tbl[idx]) : 4096;
	endfunction

	function automatic int tanh_interp(longint unsigned p, int fb);
		longint unsigned idx, frac, lo, hi;
		idx = p >> fb;
		frac = p & ((64'd1 << fb) - 1);
		lo = tbl_entry(idx);
		hi = tbl_entry(idx + 1);
		return int'(lo + (((hi - lo) * frac + (64'd1 << (fb - 1))) >> fb));
	endfunction

	function automatic bit neuron_step(in_item_t it, output out_item_t r);
		longint prod, sum;
		int c, m, t, s, act, der;
		bit nd;
		r = '0;
		prod = 0;
		der = 0;
		nd = 1'b0;
		if (it.action == ACT_WEIGHT) begin
			weights[it.weight_slot] = it.sample_value;
			return 1'b0;
		end
		if (elem_pos == 0)
			acc = 40'(longint'(bias) * 4096);
		if (elem_pos < MAX_INPUTS)
			prod = longint'(weights[elem_pos]) * longint'(it.sample_value);
		acc = acc + 40'(prod);
		if (elem_pos < 65535)
			elem_pos++;
		if (!it.last_element)
			return 1'b0;
		sum = (longint'($signed(acc)) + 2048) >>> 12;
		if (sum > 32767) sum = 32767;
		if (sum < -32768) sum = -32768;
		c = int'(sum);
		m = c < 0 ? -c : c;
		case (mode)
			MODE_LOGISTIC: begin
				t = tanh_interp(longint'(m) * TABLE_DEPTH, 16);
				if (c < 0) t = -t;
				s = (4096 + t + 1) >>> 1;
				act = s;
				der = (s * (4096 - s) + 2048) >>> 12;
			end
			MODE_TANH: begin
				t = tanh_interp(longint'(m) * TABLE_DEPTH, 15);
				act = c < 0 ? -t : t;
				der = 4096 - ((t * t + 2048) >>> 12);
			end
			MODE_STEP: begin
				act = c < 0 ? 0 : 4096;
				nd = (c == 0);
			end
			MODE_SIGN: begin
				act = c < 0 ? -4096 : 4096;
				nd = (c == 0);
			end
			default: begin
				act = c;
				der = 4096;
			end
		endcase
		r.combination_out = 16'(c);
		r.activation_out = 16'(act);
		r.derivative_out = 16'(der);
		r.not_derivable = nd;
		r.count_mismatch = (elem_pos != elem_count);
		elem_pos = 0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() > 0 && (no_idle || $urandom_range(99) >= 31)) begin
				in_item <= pending.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 31);
		end
	end

	always @(posedge clk) begin
		out_item_t r, want;
		bit busy;
		if (arst_n) begin
			busy = 1'b0;
			if (cfg_we) begin
				busy = 1'b1;
				case (cfg_index)
					REG_MODE:  mode = cfg_data[2:0];
					REG_BIAS:  bias = cfg_data;
					REG_COUNT: elem_count = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				busy = 1'b1;
				if (neuron_step(in_item, r))
					expected_q = {expected_q, r};
			end
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = expected_q.pop_front();
					if (out_item.combination_out !== want.combination_out)
						report_mismatch("combination_out", out_item.combination_out,
							want.combination_out);
					if (out_item.activation_out !== want.activation_out)
						report_mismatch("activation_out", out_item.activation_out,
							want.activation_out);
					if (out_item.derivative_out !== want.derivative_out)
						report_mismatch("derivative_out", out_item.derivative_out,
							want.derivative_out);
					if (out_item.not_derivable !== want.not_derivable)
						report_mismatch("not_derivable", out_item.not_derivable,
							want.not_derivable);
					if (out_item.count_mismatch !== want.count_mismatch)
						report_mismatch("count_mismatch", out_item.count_mismatch,
							want.count_mismatch);
				end
			end
			idle_cycles <= busy ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[perceptron_neuron] ERROR");
				$finish;
			end
		end
	end

	task automatic push_weight(int slot, logic [15:0] val, bit mark);
		in_item_t it;
		it.action = ACT_WEIGHT;
		it.weight_slot = 6'(slot);
		it.sample_value = val;
		it.last_element = mark;
		pending = {pending, it};
		slot_written[slot] = 1'b1;
	endtask

	task automatic push_element(logic [15:0] val, bit last);
		in_item_t it;
		if (gen_pos < MAX_INPUTS && !slot_written[gen_pos])
			push_weight(gen_pos, 16'($urandom), 1'($urandom));
		it.action = ACT_ELEMENT;
		it.weight_slot = 6'($urandom);
		it.sample_value = val;
		it.last_element = last;
		pending = {pending, it};
		gen_pos = last ? 0 : gen_pos + 1;
	endtask

	function automatic logic [15:0] rand_sample();
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(2047) - 1024);
	endfunction

	task automatic push_random_vector(int count);
		int len;
		case ($urandom_range(9))
			0: len = $urandom_range(1, 8);
			1: len = count + 1;
			default: len = count;
		endcase
		if ($urandom_range(40) == 0)
			len = MAX_INPUTS + 6;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 15)
				push_weight($urandom_range(MAX_INPUTS - 1), rand_sample(), 1'($urandom));
			push_element(rand_sample(), i == len - 1);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	logic [2:0]  phase_mode  [10] = '{MODE_STEP, MODE_SIGN, MODE_LOGISTIC, MODE_TANH,
		MODE_LINEAR, 3'd5, 3'd7, MODE_LOGISTIC, 3'd6, MODE_TANH};
	logic [15:0] phase_bias  [10] = '{16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h0000,
		16'h1000, 16'hf000, 16'h0000, 16'h8000, 16'h7fff};
	int          phase_count [10] = '{1, 2, 3, 64, 4, 1, 5, 2, 3, 6};

	initial begin
		int cnt;
		fill_tanh_tbl();
		for (int i = 0; i < MAX_INPUTS; i++)
			weights[i] = '0;
		acc = '0;
		elem_pos = 0;
		mode = MODE_TANH;
		bias = '0;
		elem_count = 7'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes under the reset settings, a short vector, then a rewritten weight
		push_weight(0, 16'h7fff, 1'b1);
		push_weight(1, 16'h8000, 1'b0);
		push_weight(MAX_INPUTS - 1, 16'h1000, 1'b0);
		push_element(16'h7fff, 1'b1);
		push_element(16'h8000, 1'b1);
		push_element(16'h0000, 1'b1);
		push_element(16'h0001, 1'b1);
		push_element(16'hffff, 1'b1);
		push_element(16'h7fff, 1'b0);
		push_element(16'h8000, 1'b1);
		push_weight(0, 16'h0800, 1'b0);
		push_element(16'h0800, 1'b1);
		drain();

		for (int p = 0; p < 10; p++) begin
			write_reg(REG_MODE, 16'(phase_mode[p]));
			write_reg(REG_BIAS, phase_bias[p]);
			cnt = (p == 7) ? $urandom_range(1, MAX_INPUTS) : phase_count[p];
			write_reg(REG_COUNT, 16'(cnt));
			no_idle = (p == 4);
			push_element(16'h0000, 1'b1);
			push_element(16'h7fff, 1'b1);
			push_element(16'h8000, 1'b1);
			while (pending.size() < 40)
				push_random_vector(cnt);
			drain();
		end

		if (errors == 0) begin
			$display("[perceptron_neuron] OK");
		end else begin
			$display("[perceptron_neuron] ERROR");
		end
		$finish;
	end

endmodule
